@@ src/rfbm_pkg.sv @@
// Shared constants and field codes for the reference frame buffer manager.
// No dependencies; imported by the core module.
`timescale 1ns / 1ps
`default_nettype none

package rfbm_pkg;

    // Pool size; the slot width follows from it.
    localparam int NUM_BUFFERS = 4;
    localparam int SLOT_W      = $clog2(NUM_BUFFERS);

    // Reference count storage.
    localparam int             CNT_W   = 3;
    localparam logic [CNT_W-1:0] CNT_MAX = 3'd7;

    // Width of the index fields on the result channel.
    localparam int IDX_W = 2;

    // Item mode.
    localparam logic MODE_ALLOC  = 1'b0;
    localparam logic MODE_COMMIT = 1'b1;

    // Copy selectors.
    localparam logic [1:0] COPY_NONE    = 2'd0;
    localparam logic [1:0] COPY_LAST    = 2'd1;
    localparam logic [1:0] COPY_OTHER   = 2'd2;
    localparam logic [1:0] COPY_INVALID = 2'd3;

    // Result status codes.
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NO_FREE = 2'd1;
    localparam logic [1:0] STATUS_BAD_SEL = 2'd2;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [CNT_W-1:0]  cnt_t;

endpackage

`default_nettype wire

@@ src/reference_frame_buffer_manager_core.sv @@
// Reference frame buffer manager: reference counts and role pointers for the
// frame buffer pool, updated through one shared count update unit.
// Depends on rfbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Allocate examines one buffer per cycle from slot 0 and claims the first free one;
// commit applies each enabled role update through the shared count unit as a release of
// the old buffer then a claim of the target, skips disabled steps, releases the new buffer
// and loads the result. One item in work at a time and s_ready high only when idle, so a
// new item waits until the last is done, also while a waiting result holds the register.
// Reset (synchronous, aresetn low): counts 0,1,1,1, new 0, last 1, golden 2, alt 3.
module reference_frame_buffer_manager_core
    import rfbm_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,

    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic             s_mode,
    input  wire logic             s_refresh_last,
    input  wire logic             s_refresh_golden,
    input  wire logic             s_refresh_alt,
    input  wire logic [1:0]       s_copy_to_alt,
    input  wire logic [1:0]       s_copy_to_golden,

    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [IDX_W-1:0]      m_buffer_index,
    output logic [1:0]            m_status,
    output logic [IDX_W-1:0]      m_last_index,
    output logic [IDX_W-1:0]      m_golden_index,
    output logic [IDX_W-1:0]      m_alt_index
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_COMMIT,
        ST_FINISH
    } state_t;

    // Commit steps, in the order the role updates must apply.
    typedef enum logic [2:0] {
        STEP_COPY_ALT,
        STEP_COPY_GOLD,
        STEP_REF_GOLD,
        STEP_REF_ALT,
        STEP_REF_LAST,
        STEP_RELEASE
    } step_t;

    typedef enum logic [1:0] {
        ROLE_ALT,
        ROLE_GOLD,
        ROLE_LAST
    } role_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_DEC,
        OP_INC,
        OP_SET
    } op_t;

    localparam slot_t LAST_SLOT = SLOT_W'(NUM_BUFFERS - 1);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    state_t     state_reg, state_next;
    step_t      step_reg, step_next;
    logic       half_reg, half_next;      // 0: release old buffer, 1: claim target
    slot_t      scan_reg, scan_next;

    cnt_t       counts_reg [NUM_BUFFERS];
    cnt_t       counts_next [NUM_BUFFERS];
    slot_t      new_reg, new_next;
    slot_t      last_reg, last_next;
    slot_t      gold_reg, gold_next;
    slot_t      alt_reg, alt_next;

    // Captured item flags.
    logic       r_last_reg, r_last_next;
    logic       r_gold_reg, r_gold_next;
    logic       r_alt_reg, r_alt_next;
    logic [1:0] c_alt_reg, c_alt_next;
    logic [1:0] c_gold_reg, c_gold_next;
    slot_t      src_reg, src_next;        // source for selector "from last-or-new"

    // Result being built and result register.
    slot_t      shown_reg, shown_next;
    logic [1:0] status_reg, status_next;
    logic       m_valid_reg, m_valid_next;
    logic [IDX_W-1:0] m_buf_reg, m_buf_next;
    logic [1:0]       m_status_reg, m_status_next;
    logic [IDX_W-1:0] m_last_reg, m_last_next;
    logic [IDX_W-1:0] m_gold_reg, m_gold_next;
    logic [IDX_W-1:0] m_alt_reg, m_alt_next;

    // ------------------------------------------------------------------
    // Commit step decode
    // ------------------------------------------------------------------
    logic       step_en;
    logic       step_bad;
    role_t      step_role;
    slot_t      step_target;
    slot_t      role_cur;

    always_comb begin
        step_en     = 1'b0;
        step_bad    = 1'b0;
        step_role   = ROLE_ALT;
        step_target = '0;
        case (step_reg)
            STEP_COPY_ALT: begin
                step_en   = (c_alt_reg != COPY_NONE);
                step_role = ROLE_ALT;
                step_bad  = (c_alt_reg == COPY_INVALID);
                case (c_alt_reg)
                    COPY_LAST:  step_target = src_reg;
                    COPY_OTHER: step_target = gold_reg;
                    default:    step_target = '0;
                endcase
            end
            STEP_COPY_GOLD: begin
                step_en   = (c_gold_reg != COPY_NONE);
                step_role = ROLE_GOLD;
                step_bad  = (c_gold_reg == COPY_INVALID);
                // alt_reg already holds the result of the alternate copy
                case (c_gold_reg)
                    COPY_LAST:  step_target = src_reg;
                    COPY_OTHER: step_target = alt_reg;
                    default:    step_target = '0;
                endcase
            end
            STEP_REF_GOLD: begin
                step_en     = r_gold_reg;
                step_role   = ROLE_GOLD;
                step_target = new_reg;
            end
            STEP_REF_ALT: begin
                step_en     = r_alt_reg;
                step_role   = ROLE_ALT;
                step_target = new_reg;
            end
            STEP_REF_LAST: begin
                step_en     = r_last_reg;
                step_role   = ROLE_LAST;
                step_target = new_reg;
            end
            default: begin
                step_en = 1'b0;
            end
        endcase

        case (step_role)
            ROLE_GOLD: role_cur = gold_reg;
            ROLE_LAST: role_cur = last_reg;
            default:   role_cur = alt_reg;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer and shared count update unit
    // ------------------------------------------------------------------
    slot_t u_slot;
    op_t   u_op;
    cnt_t  u_cnt;
    cnt_t  u_res;

    assign s_ready = (state_reg == ST_IDLE);
    assign u_cnt   = counts_reg[u_slot];

    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        half_next     = half_reg;
        scan_next     = scan_reg;
        counts_next   = counts_reg;
        new_next      = new_reg;
        last_next     = last_reg;
        gold_next     = gold_reg;
        alt_next      = alt_reg;
        r_last_next   = r_last_reg;
        r_gold_next   = r_gold_reg;
        r_alt_next    = r_alt_reg;
        c_alt_next    = c_alt_reg;
        c_gold_next   = c_gold_reg;
        src_next      = src_reg;
        shown_next    = shown_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg;
        m_buf_next    = m_buf_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;
        m_gold_next   = m_gold_reg;
        m_alt_next    = m_alt_reg;
        u_slot        = scan_reg;
        u_op          = OP_NONE;

        // Drop the result once the consumer takes it.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    r_last_next = s_refresh_last;
                    r_gold_next = s_refresh_golden;
                    r_alt_next  = s_refresh_alt;
                    c_alt_next  = s_copy_to_alt;
                    c_gold_next = s_copy_to_golden;
                    src_next    = s_refresh_last ? last_reg : new_reg;
                    status_next = STATUS_OK;
                    scan_next   = '0;
                    step_next   = STEP_COPY_ALT;
                    half_next   = 1'b0;
                    state_next  = (s_mode == MODE_ALLOC) ? ST_ALLOC : ST_COMMIT;
                end
            end

            ST_ALLOC: begin
                // Examine one buffer per cycle, claim the first free one.
                u_slot = scan_reg;
                if (u_cnt == '0) begin
                    u_op       = OP_SET;
                    new_next   = scan_reg;
                    shown_next = scan_reg;
                    state_next = ST_FINISH;
                end else if (scan_reg == LAST_SLOT) begin
                    // Pool exhausted: clear every count, keep new slot.
                    for (int i = 0; i < NUM_BUFFERS; i++) begin
                        counts_next[i] = '0;
                    end
                    shown_next  = '0;
                    status_next = STATUS_NO_FREE;
                    state_next  = ST_FINISH;
                end else begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            ST_COMMIT: begin
                if (step_reg == STEP_RELEASE) begin
                    u_slot     = new_reg;
                    u_op       = OP_DEC;
                    shown_next = new_reg;
                    state_next = ST_FINISH;
                end else if (!step_en) begin
                    step_next = step_t'(step_reg + 3'd1);
                    half_next = 1'b0;
                end else if (!half_reg) begin
                    // Release the buffer the role currently holds.
                    u_slot    = role_cur;
                    u_op      = OP_DEC;
                    half_next = 1'b1;
                end else begin
                    // Point the role at its target and claim it.
                    u_slot = step_target;
                    u_op   = OP_INC;
                    case (step_role)
                        ROLE_GOLD: gold_next = step_target;
                        ROLE_LAST: last_next = step_target;
                        default:   alt_next  = step_target;
                    endcase
                    if (step_bad) begin
                        status_next = STATUS_BAD_SEL;
                    end
                    step_next = step_t'(step_reg + 3'd1);
                    half_next = 1'b0;
                end
            end

            ST_FINISH: begin
                // Hold until the result register is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_buf_next    = shown_reg[IDX_W-1:0];
                    m_status_next = status_reg;
                    m_last_next   = last_reg[IDX_W-1:0];
                    m_gold_next   = gold_reg[IDX_W-1:0];
                    m_alt_next    = alt_reg[IDX_W-1:0];
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Saturating count update, one buffer per cycle.
        case (u_op)
            OP_DEC:  u_res = (u_cnt != '0) ? u_cnt - 1'b1 : u_cnt;
            OP_INC:  u_res = (u_cnt != CNT_MAX) ? u_cnt + 1'b1 : u_cnt;
            OP_SET:  u_res = CNT_W'(1);
            default: u_res = u_cnt;
        endcase
        if (u_op != OP_NONE) begin
            counts_next[u_slot] = u_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= STEP_COPY_ALT;
            half_reg    <= 1'b0;
            scan_reg    <= '0;
            for (int i = 0; i < NUM_BUFFERS; i++) begin
                counts_reg[i] <= (i == 0) ? CNT_W'(0) : CNT_W'(1);
            end
            new_reg     <= SLOT_W'(0);
            last_reg    <= SLOT_W'(1);
            gold_reg    <= SLOT_W'(2);
            alt_reg     <= SLOT_W'(3);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            half_reg    <= half_next;
            scan_reg    <= scan_next;
            counts_reg  <= counts_next;
            new_reg     <= new_next;
            last_reg    <= last_next;
            gold_reg    <= gold_next;
            alt_reg     <= alt_next;
            m_valid_reg <= m_valid_next;
        end
        r_last_reg   <= r_last_next;
        r_gold_reg   <= r_gold_next;
        r_alt_reg    <= r_alt_next;
        c_alt_reg    <= c_alt_next;
        c_gold_reg   <= c_gold_next;
        src_reg      <= src_next;
        shown_reg    <= shown_next;
        status_reg   <= status_next;
        m_buf_reg    <= m_buf_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
        m_gold_reg   <= m_gold_next;
        m_alt_reg    <= m_alt_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_buffer_index = m_buf_reg;
    assign m_status       = m_status_reg;
    assign m_last_index   = m_last_reg;
    assign m_golden_index = m_gold_reg;
    assign m_alt_index    = m_alt_reg;

endmodule

`default_nettype wire
